// File: rtl/core/gss_pkg.sv
package gss_pkg;

    // Configuration port and field widths
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int GW_W        = 13;
    localparam int GH_W        = 16;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 16;
    localparam int VALUE_W     = 16;

    // Entries in the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [GW_W-1:0] GW_RESET = 13'd4096;
    localparam logic [GH_W-1:0] GH_RESET = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MODE_JACOBI   = 1'b0,
        MODE_BINOMIAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [GW_W-1:0]  width;
        logic [GH_W-1:0]  height;
    } t_cfg;

endpackage

// File: rtl/core/gss_fifo.sv
module gss_fifo
    import gss_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Hold queued transactions
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

// File: rtl/core/gss_front.sv
module gss_front
    import gss_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    output logic                    o_stall,
    output logic                    o_push,
    output logic [9*SAMPLE_BITS+COL_W+ROW_W:0] o_item,
    input  logic                    i_full
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Row stores: two rows above the current one
    logic [SAMPLE_BITS-1:0] r_store_upper  [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] r_store_middle [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] r_rd_upper;
    logic [SAMPLE_BITS-1:0] r_rd_middle;

    // Raster position of the next sample
    logic [CW-1:0]   r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]   n_col;
    logic [ROW_W-1:0] n_row;

    // Sample waiting for its row store data
    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    logic [CW-1:0]          r_a_x;
    logic [COL_W-1:0]       r_a_col;
    logic [ROW_W-1:0]       r_a_row;
    logic                   r_a_emit;
    logic                   r_a_last;

    // Window: left column then centre column, top to bottom
    logic [SAMPLE_BITS-1:0] r_win [6];

    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic             end_row;
    logic             end_frame;
    logic             in_acc;
    logic             a_fire;

    // Clamp geometry to the supported range
    always_comb begin
        if (i_cfg.width < GW_W'(3)) begin
            w_last = CW'(2);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(i_cfg.width - GW_W'(1));
        end
        if (i_cfg.height < GH_W'(3)) begin
            h_last = ROW_W'(2);
        end else begin
            h_last = ROW_W'(i_cfg.height - GH_W'(1));
        end
    end

    assign end_row   = (r_col >= w_last);
    assign end_frame = end_row && (r_row >= h_last);

    // Handshake: advance when the queue has room or nothing goes out
    assign a_fire  = r_a_valid && (!r_a_emit || !i_full);
    assign o_stall = r_a_valid && !a_fire;
    assign in_acc  = i_valid && !o_stall;
    assign o_push  = a_fire && r_a_emit;

    // Step the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (end_row) begin
                n_col = '0;
                n_row = end_frame ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Capture the incoming transaction and classify it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample <= i_sample;
            r_a_x      <= r_col;
            r_a_col    <= COL_W'(r_col - CW'(1));
            r_a_row    <= r_row - 1'b1;
            r_a_emit   <= (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
            r_a_last   <= end_frame;
        end
    end

    // Read the row stores on accept, shift them down on advance
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_store_upper[r_a_x]  <= r_rd_middle;
            r_store_middle[r_a_x] <= r_a_sample;
        end
        if (in_acc) begin
            r_rd_upper  <= r_store_upper[r_col];
            r_rd_middle <= r_store_middle[r_col];
        end
    end

    // Slide the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (a_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_rd_upper;
            r_win[4] <= r_rd_middle;
            r_win[5] <= r_a_sample;
        end
    end

    // Pack the full 3x3 neighborhood with its position
    assign o_item = {r_win[0], r_win[1], r_win[2],
                     r_win[3], r_win[4], r_win[5],
                     r_rd_upper, r_rd_middle, r_a_sample,
                     r_a_col, r_a_row, r_a_last};

endmodule

// File: rtl/core/gss_back.sv
module gss_back
    import gss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mode                   i_mode,
    input  logic                    i_not_empty,
    input  logic [9*SAMPLE_BITS+COL_W+ROW_W:0] i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [VALUE_W-1:0]      o_value,
    output logic [COL_W-1:0]        o_col,
    output logic [ROW_W-1:0]        o_row,
    output logic                    o_last
);

    localparam int SB  = SAMPLE_BITS;
    localparam int POS = COL_W + ROW_W + 1;

    logic [SB-1:0] nw, wv, sw, nv, c, sv, ne, ev, se;
    logic [COL_W-1:0] in_col;
    logic [ROW_W-1:0] in_row;
    logic             in_last;

    // First stage: partial sums
    logic             r_s1_valid;
    logic [SB+1:0]    r_s1_cross;
    logic [SB+1:0]    r_s1_corner;
    logic [SB-1:0]    r_s1_center;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_last;

    // Output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_last;

    logic          out_ready;
    logic          s1_ready;
    logic          s1_fire;
    logic [SB+3:0] weighted;
    logic [SB-1:0] n_value;

    assign {nw, wv, sw, nv, c, sv, ne, ev, se} = i_item[9*SB+POS-1:POS];
    assign {in_col, in_row, in_last}           = i_item[POS-1:0];

    // Handshake through the two stages
    assign out_ready = !r_out_valid || !i_stall;
    assign s1_fire   = r_s1_valid && out_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = i_not_empty && s1_ready;

    // Final weighting and truncating shift
    always_comb begin
        weighted = {r_s1_center, 4'b0000} >> 2;
        weighted = weighted + {1'b0, r_s1_cross, 1'b0} + {2'b00, r_s1_corner};
        case (i_mode)
            MODE_JACOBI:   n_value = r_s1_cross[SB+1:2];
            MODE_BINOMIAL: n_value = weighted[SB+3:4];
            default:       n_value = r_s1_cross[SB+1:2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Add the cross and the corners
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cross  <= (SB+2)'(nv) + (SB+2)'(sv) + (SB+2)'(ev) + (SB+2)'(wv);
            r_s1_corner <= (SB+2)'(nw) + (SB+2)'(ne) + (SB+2)'(sw) + (SB+2)'(se);
            r_s1_center <= c;
            r_s1_col    <= in_col;
            r_s1_row    <= in_row;
            r_s1_last   <= in_last;
        end
    end

    // Load the output register, hold it while stalled
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_value <= VALUE_W'(n_value);
            r_out_col   <= r_s1_col;
            r_out_row   <= r_s1_row;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_col   = r_out_col;
    assign o_row   = r_out_row;
    assign o_last  = r_out_last;

endmodule

// File: rtl/core/grid_stencil_smoother.sv
// Streaming 3x3 grid smoother.
// Input channel: i_valid / o_stall carry one grid sample per transaction, in
// raster order, halo rows and columns included. Output channel: o_valid /
// i_stall carry one smoothed interior point with its column, row and a
// last flag set on the final interior point of the frame. Samples in the
// first two columns or rows of the grid produce no output transaction.
// Mode 0 gives the Jacobi average of the north, south, east and west
// neighbours, mode 1 the 9-point binomial smoother; both truncate. The
// user must write registers through i_cfg_we, i_cfg_idx and i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Throughput: one sample per clock while o_stall is low. A sample passes
// the row store read, the queue, the adder stage and the output register.
// A receiver stall fills the output register, then the adder stage, then
// the four-entry queue; only then does o_stall rise on the input side.
// Reset (synchronous, active low) clears the raster position, the window,
// all valid flags and the registers (mode 0, width 4096, height 4096).
// Row stores hold no reset value and need no clearing pass.
module grid_stencil_smoother
    import gss_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_W-1:0]     o_value,
    output logic [COL_W-1:0]       o_col,
    output logic [ROW_W-1:0]       o_row,
    output logic                   o_last
);

    localparam int ITEM_W = 9 * SAMPLE_BITS + COL_W + ROW_W + 1;

    t_mode           r_mode;
    logic [GW_W-1:0] r_width;
    logic [GH_W-1:0] r_height;
    t_cfg            cfg;

    logic              q_push;
    logic [ITEM_W-1:0] q_wr_item;
    logic              q_full;
    logic              q_pop;
    logic [ITEM_W-1:0] q_rd_item;
    logic              q_not_empty;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_JACOBI;
            r_width  <= GW_RESET;
            r_height <= GH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[0]);
                CFG_WIDTH:  r_width  <= i_cfg_data[GW_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[GH_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = '{mode: r_mode, width: r_width, height: r_height};

    gss_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_stall  (o_stall),
        .o_push   (q_push),
        .o_item   (q_wr_item),
        .i_full   (q_full)
    );

    gss_fifo #(
        .DATA_W (ITEM_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_data      (q_wr_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_data      (q_rd_item),
        .o_not_empty (q_not_empty)
    );

    gss_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_not_empty (q_not_empty),
        .i_item      (q_rd_item),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_col       (o_col),
        .o_row       (o_row),
        .o_last      (o_last)
    );

endmodule
